// ----- hdl/board_power_sequencer_defines.svh -----
// Assertion macros for the board power sequencer.
`ifndef BOARD_POWER_SEQUENCER_DEFINES_SVH
`define BOARD_POWER_SEQUENCER_DEFINES_SVH

`ifndef SYNTH

// Plain property check, disabled while reset is held.
`define BPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check, disabled while reset is held.
`define BPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define BPS_ASSERT(label, clk, rst_n, prop, msg)
`define BPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/bps_pkg.sv -----
// Shared types and constants for the board power sequencer.
`default_nettype none

package bps_pkg;

    localparam int unsigned SCAN_PERIOD_MS = 20;
    localparam int unsigned SCAN_W         = $clog2(SCAN_PERIOD_MS + 1);
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_PRESS   = 3'd0,
        CFG_LONG_PRESS    = 3'd1,
        CFG_RESET_PRESS   = 3'd2,
        CFG_HOST_BTN_ON   = 3'd3,
        CFG_HOST_BTN_OFF  = 3'd4,
        CFG_STOP_TIMEOUT  = 3'd5,
        CFG_QUIESCE       = 3'd6,
        CFG_RESET_PULSE   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] short_press_ms;
        logic [15:0] long_press_ms;
        logic [15:0] reset_press_ms;
        logic [15:0] host_button_on_ms;
        logic [15:0] host_button_off_ms;
        logic [15:0] stop_wait_ms;
        logic [15:0] quiesce_ms;
        logic [7:0]  reset_pulse_ms;
    } t_cfg;

    localparam logic [15:0] DEF_SHORT_PRESS  = 16'd100;
    localparam logic [15:0] DEF_LONG_PRESS   = 16'd4000;
    localparam logic [15:0] DEF_RESET_PRESS  = 16'd1000;
    localparam logic [15:0] DEF_HOST_BTN_ON  = 16'd1000;
    localparam logic [15:0] DEF_HOST_BTN_OFF = 16'd4000;
    localparam logic [15:0] DEF_STOP_TIMEOUT = 16'd6000;
    localparam logic [15:0] DEF_QUIESCE      = 16'd100;
    localparam logic [7:0]  DEF_RESET_PULSE  = 8'd50;

    typedef struct packed {
        logic power_key_n;
        logic reset_key_n;
        logic endpoint_power_good;
        logic endpoint_config_done;
        logic host_sleep_n;
    } t_in;

    typedef enum logic [1:0] {
        SYS_OFF  = 2'd0,
        SYS_UP   = 2'd1,
        SYS_ON   = 2'd2,
        SYS_DOWN = 2'd3
    } t_sys;

    typedef enum logic [3:0] {
        PH_IDLE         = 4'd0,
        PH_WAIT_PG      = 4'd1,
        PH_WAIT_DONE    = 4'd2,
        PH_HOST_BTN_ON  = 4'd3,
        PH_WAIT_HOST    = 4'd4,
        PH_SOFT_QUIESCE = 4'd5,
        PH_HARD_BTN     = 4'd6,
        PH_WAIT_STOP    = 4'd7,
        PH_HARD_QUIESCE = 4'd8
    } t_phase;

    typedef struct packed {
        logic host_main_power;
        logic host_reset_n;
        logic endpoint_power;
        logic endpoint_reset_n;
        logic endpoint_program_n;
        logic host_button_n;
        logic host_power_ok;
        logic led_power_good;
        logic led_host_started;
        logic led_config_done;
    } t_pins;

    localparam t_pins PINS_RESET = '{
        host_main_power:    1'b0,
        host_reset_n:       1'b0,
        endpoint_power:     1'b0,
        endpoint_reset_n:   1'b0,
        endpoint_program_n: 1'b1,
        host_button_n:      1'b1,
        host_power_ok:      1'b0,
        led_power_good:     1'b0,
        led_host_started:   1'b0,
        led_config_done:    1'b0
    };

    typedef struct packed {
        logic       host_main_power;
        logic       host_reset_n;
        logic       endpoint_power;
        logic       endpoint_reset_n;
        logic       endpoint_program_n;
        logic       host_button_n;
        logic       host_power_ok;
        logic       led_power_good;
        logic       led_host_started;
        logic       led_config_done;
        logic [1:0] power_state;
    } t_out;

    // Button events of one tick, from the scanner to the sequencer.
    typedef struct packed {
        logic want_hard;
        logic want_up;
        logic rst_low;
        logic rst_high;
    } t_scan_evt;

endpackage

`default_nettype wire

// ----- hdl/bps_cfg.sv -----
// Configuration register file of the board power sequencer.
`default_nettype none

module bps_cfg (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_valid,
    input  wire  [bps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [bps_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output bps_pkg::t_cfg                        o_cfg
);
    import bps_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_cfg_idx w_idx;

    assign w_idx = t_cfg_idx'(i_cfg_index);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (w_idx)
                CFG_SHORT_PRESS:  n_cfg.short_press_ms       = i_cfg_data;
                CFG_LONG_PRESS:   n_cfg.long_press_ms        = i_cfg_data;
                CFG_RESET_PRESS:  n_cfg.reset_press_ms       = i_cfg_data;
                CFG_HOST_BTN_ON:  n_cfg.host_button_on_ms    = i_cfg_data;
                CFG_HOST_BTN_OFF: n_cfg.host_button_off_ms   = i_cfg_data;
                CFG_STOP_TIMEOUT: n_cfg.stop_wait_ms         = i_cfg_data;
                CFG_QUIESCE:      n_cfg.quiesce_ms           = i_cfg_data;
                CFG_RESET_PULSE:  n_cfg.reset_pulse_ms       = i_cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_press_ms       <= DEF_SHORT_PRESS;
            r_cfg.long_press_ms        <= DEF_LONG_PRESS;
            r_cfg.reset_press_ms       <= DEF_RESET_PRESS;
            r_cfg.host_button_on_ms    <= DEF_HOST_BTN_ON;
            r_cfg.host_button_off_ms   <= DEF_HOST_BTN_OFF;
            r_cfg.stop_wait_ms         <= DEF_STOP_TIMEOUT;
            r_cfg.quiesce_ms           <= DEF_QUIESCE;
            r_cfg.reset_pulse_ms       <= DEF_RESET_PULSE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hdl/bps_scan.sv -----
// Button scanner, press classification and host reset pulse timer.
`default_nettype none

module bps_scan (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_step,
    input  wire                   i_power_key_n,
    input  wire                   i_reset_key_n,
    input  bps_pkg::t_cfg         i_cfg,
    output bps_pkg::t_scan_evt    o_evt
);
    import bps_pkg::*;

    localparam logic [SCAN_W-1:0] PRESC_LAST = SCAN_W'(SCAN_PERIOD_MS - 1);

    logic [SCAN_W-1:0] r_presc,     n_presc;
    logic              r_pwr_held,  n_pwr_held;
    logic [15:0]       r_pwr_time,  n_pwr_time;
    logic              r_rst_held,  n_rst_held;
    logic [15:0]       r_rst_time,  n_rst_time;
    logic [7:0]        r_pulse,     n_pulse;
    logic              w_scan;
    logic              w_trigger;
    t_scan_evt         w_evt;

    // Held time grows by one scan period, saturating.
    function automatic logic [15:0] add_scan(input logic [15:0] a);
        logic [16:0] s;
        s = {1'b0, a} + 17'(SCAN_PERIOD_MS);
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    assign w_scan = (r_presc == '0);

    always_comb begin
        n_presc    = (r_presc == PRESC_LAST) ? '0 : r_presc + 1'b1;
        n_pwr_held = r_pwr_held;
        n_pwr_time = r_pwr_time;
        n_rst_held = r_rst_held;
        n_rst_time = r_rst_time;
        w_evt      = '0;
        w_trigger  = 1'b0;

        if (w_scan) begin
            if (!i_power_key_n) begin
                n_pwr_held = 1'b1;
                n_pwr_time = r_pwr_held ? add_scan(r_pwr_time) : 16'd0;
            end else if (r_pwr_held) begin
                if (r_pwr_time >= i_cfg.long_press_ms) begin
                    w_evt.want_hard = 1'b1;
                end else if (r_pwr_time >= i_cfg.short_press_ms) begin
                    w_evt.want_up = 1'b1;
                end
                n_pwr_held = 1'b0;
                n_pwr_time = 16'd0;
            end

            if (!i_reset_key_n) begin
                n_rst_held = 1'b1;
                n_rst_time = r_rst_held ? add_scan(r_rst_time) : 16'd0;
            end else if (r_rst_held) begin
                w_trigger  = (r_rst_time >= i_cfg.reset_press_ms);
                n_rst_held = 1'b0;
                n_rst_time = 16'd0;
            end
        end

        // pulse end first, a new trigger overrides it
        w_evt.rst_high = (r_pulse == 8'd1);
        w_evt.rst_low  = w_trigger;
        if (w_trigger) begin
            n_pulse = (i_cfg.reset_pulse_ms == 8'd0) ? 8'd1 : i_cfg.reset_pulse_ms;
        end else if (r_pulse != 8'd0) begin
            n_pulse = r_pulse - 8'd1;
        end else begin
            n_pulse = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc    <= '0;
            r_pwr_held <= 1'b0;
            r_pwr_time <= 16'd0;
            r_rst_held <= 1'b0;
            r_rst_time <= 16'd0;
            r_pulse    <= 8'd0;
        end else if (i_step) begin
            r_presc    <= n_presc;
            r_pwr_held <= n_pwr_held;
            r_pwr_time <= n_pwr_time;
            r_rst_held <= n_rst_held;
            r_rst_time <= n_rst_time;
            r_pulse    <= n_pulse;
        end
    end

    assign o_evt = w_evt;

endmodule

`default_nettype wire

// ----- hdl/bps_seq.sv -----
// Power sequencing state machine and pin drive registers.
`default_nettype none

module bps_seq (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_step,
    input  bps_pkg::t_scan_evt    i_evt,
    input  wire                   i_power_good,
    input  wire                   i_config_done,
    input  wire                   i_sleep_n,
    input  bps_pkg::t_cfg         i_cfg,
    output bps_pkg::t_out         o_next
);
    import bps_pkg::*;

`include "board_power_sequencer_defines.svh"

    t_sys        r_sys,   n_sys;
    t_phase      r_phase, n_phase;
    logic [15:0] r_timer, n_timer;
    t_pins       r_pins,  n_pins;
    logic        w_expired;
    logic [15:0] w_timer_dec;

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    assign w_expired   = (r_timer <= 16'd1);
    assign w_timer_dec = w_expired ? 16'd0 : r_timer - 16'd1;

    always_comb begin
        n_sys   = r_sys;
        n_phase = r_phase;
        n_timer = r_timer;
        n_pins  = r_pins;

        if (i_evt.rst_high) n_pins.host_reset_n = 1'b1;
        if (i_evt.rst_low)  n_pins.host_reset_n = 1'b0;

        if (i_evt.want_hard && r_sys != SYS_DOWN) begin
            n_sys                = SYS_DOWN;
            n_pins.host_button_n = 1'b0;
            n_timer              = at_least_one(i_cfg.host_button_off_ms);
            n_phase              = PH_HARD_BTN;
        end else if (i_evt.want_up && r_sys == SYS_OFF) begin
            n_sys                  = SYS_UP;
            n_pins.host_main_power = 1'b1;
            n_pins.host_reset_n    = 1'b1;
            n_pins.endpoint_power  = 1'b1;
            n_timer                = 16'd0;
            n_phase                = PH_WAIT_PG;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (r_sys == SYS_ON && !i_sleep_n) begin
                        n_sys                     = SYS_DOWN;
                        n_pins.host_power_ok      = 1'b0;
                        n_pins.host_reset_n       = 1'b0;
                        n_pins.endpoint_reset_n   = 1'b0;
                        n_pins.endpoint_program_n = 1'b0;
                        n_timer                   = at_least_one(i_cfg.quiesce_ms);
                        n_phase                   = PH_SOFT_QUIESCE;
                    end
                end
                PH_WAIT_PG: begin
                    if (i_power_good) begin
                        n_pins.led_power_good     = 1'b1;
                        n_pins.endpoint_program_n = 1'b1;
                        n_pins.endpoint_reset_n   = 1'b1;
                        n_phase                   = PH_WAIT_DONE;
                    end
                end
                PH_WAIT_DONE: begin
                    if (i_config_done) begin
                        n_pins.led_config_done = 1'b1;
                        n_pins.host_button_n   = 1'b0;
                        n_timer                = at_least_one(i_cfg.host_button_on_ms);
                        n_phase                = PH_HOST_BTN_ON;
                    end
                end
                PH_HOST_BTN_ON: begin
                    n_timer = w_timer_dec;
                    if (w_expired) begin
                        n_pins.host_button_n = 1'b1;
                        n_phase              = PH_WAIT_HOST;
                    end
                end
                PH_WAIT_HOST: begin
                    if (i_sleep_n) begin
                        n_pins.host_power_ok    = 1'b1;
                        n_pins.led_host_started = 1'b1;
                        n_sys                   = SYS_ON;
                        n_phase                 = PH_IDLE;
                    end
                end
                PH_SOFT_QUIESCE, PH_HARD_QUIESCE: begin
                    n_timer = w_timer_dec;
                    if (w_expired) begin
                        // everything off
                        n_pins.endpoint_power   = 1'b0;
                        n_pins.host_power_ok    = 1'b0;
                        n_pins.host_main_power  = 1'b0;
                        n_pins.led_power_good   = 1'b0;
                        n_pins.led_host_started = 1'b0;
                        n_pins.led_config_done  = 1'b0;
                        n_sys                   = SYS_OFF;
                        n_phase                 = PH_IDLE;
                        n_timer                 = 16'd0;
                    end
                end
                PH_HARD_BTN: begin
                    n_timer = w_timer_dec;
                    if (w_expired) begin
                        n_pins.host_button_n = 1'b1;
                        n_phase              = PH_WAIT_STOP;
                    end
                end
                PH_WAIT_STOP: begin
                    if (!i_sleep_n || r_timer >= i_cfg.stop_wait_ms) begin
                        n_pins.host_reset_n       = 1'b0;
                        n_pins.endpoint_reset_n   = 1'b0;
                        n_pins.endpoint_program_n = 1'b0;
                        n_timer                   = at_least_one(i_cfg.quiesce_ms);
                        n_phase                   = PH_HARD_QUIESCE;
                    end else if (r_timer != 16'hFFFF) begin
                        n_timer = r_timer + 16'd1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_timer = 16'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys   <= SYS_OFF;
            r_phase <= PH_IDLE;
            r_timer <= 16'd0;
            r_pins  <= PINS_RESET;
        end else if (i_step) begin
            r_sys   <= n_sys;
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_pins  <= n_pins;
        end
    end

    assign o_next = {n_pins, n_sys};

    `BPS_ASSERT_IMP(a_off_rails_low, i_clk, i_rst_n, r_sys == SYS_OFF,
        !r_pins.host_main_power && !r_pins.endpoint_power, "rails enabled while off")
    `BPS_ASSERT(a_idle_iff_steady, i_clk, i_rst_n,
        (r_phase == PH_IDLE) == (r_sys == SYS_OFF || r_sys == SYS_ON),
        "phase and system state disagree")
    `BPS_ASSERT_IMP(a_idle_timer_clear, i_clk, i_rst_n, r_phase == PH_IDLE,
        r_timer == 16'd0, "timer running while idle")

endmodule

`default_nettype wire

// ----- hdl/board_power_sequencer.sv -----
// Top level of the board power sequencer: handshakes, result register, submodules.
`default_nettype none

// Board power sequencer. Each input transfer is one 1 ms tick carrying the
// sampled button, power-good, done and host sleep pins; each tick yields
// exactly one result transfer with the pin drives and the power state after
// that tick. Buttons are scanned on the first tick after reset and every
// SCAN_PERIOD_MS ticks after. A tick can be taken in every clock cycle that
// o_in_stall is low: its work is one pass of compare-and-count logic from the
// state registers into a result register, so throughput is one tick per clock
// unless stalled; the result is valid the cycle after the input transfer.
// o_in_stall goes high only while the result register holds an untaken result
// and the downstream side stalls. The eight timing registers reset to their
// defaults and are written through the config port, which is always ready;
// write them only while the block is idle.
module board_power_sequencer (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // tick input
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  bps_pkg::t_in                     i_in_data,
    // result output
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output bps_pkg::t_out                    o_out_data,
    // config writes
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [bps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [bps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bps_pkg::*;

    logic      w_step;       // input transfer this cycle
    t_cfg      w_cfg;
    t_scan_evt w_evt;
    t_out      w_next;
    logic      r_out_valid;
    t_out      r_out_data;

    // Result register frees up when its content is taken this cycle.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_step     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    bps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    bps_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_power_key_n (i_in_data.power_key_n),
        .i_reset_key_n (i_in_data.reset_key_n),
        .i_cfg         (w_cfg),
        .o_evt         (w_evt)
    );

    bps_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_evt         (w_evt),
        .i_power_good  (i_in_data.endpoint_power_good),
        .i_config_done (i_in_data.endpoint_config_done),
        .i_sleep_n     (i_in_data.host_sleep_n),
        .i_cfg         (w_cfg),
        .o_next        (w_next)
    );

    // Result register: loaded on every input transfer, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= w_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ----- bench/tb_board_power_sequencer.sv -----
// Self-checking testbench for the board power sequencer: tick stimulus, predicted pin drives.
module tb_board_power_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and the signals around the block
    // ------------------------------------------------------------------
    logic      clk = 1'b0;
    logic      rst_n = 1'b0;

    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in       in_data = '1;

    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out      out_data;

    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    t_cfg_idx  cfg_index = CFG_SHORT_PRESS;
    logic [15:0] cfg_data = '0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    board_power_sequencer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_in  pending_ticks [$];   // ticks waiting for the driver
    t_out want_drives [$];     // predicted pin drives, oldest first

    int send_idle_pct = 31;    // chance per cycle that the sender holds off
    int recv_idle_pct = 54;    // chance per cycle that the receiver stalls

    int n_errors   = 0;
    int n_ticks    = 0;        // tick transfers accepted by the block
    int ticks_made = 0;        // ticks generated so far
    int n_settings = 0;
    int n_on       = 0;
    int n_hard     = 0;
    int n_soft     = 0;
    int n_pulses   = 0;

    // Environment pins seen by the block during random stimulus.
    logic env_pg = 1'b0;
    logic env_dn = 1'b0;
    logic env_sl = 1'b1;
    int   env_dwell = 0;

    // ------------------------------------------------------------------
    // Sequencer prediction: own copy of the timing registers and state
    // ------------------------------------------------------------------
    t_cfg        cfg;
    t_sys        sys_st;
    t_phase      seq_phase;
    logic [15:0] ph_timer;
    int unsigned scan_div;
    logic        pk_held;
    logic [15:0] pk_time;
    logic        rk_held;
    logic [15:0] rk_time;
    logic [7:0]  rst_pulse;
    t_pins       pins;

    function automatic logic [15:0] sat_add(logic [15:0] a, int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
    endfunction

    // Zero-length waits behave as one tick.
    function automatic logic [15:0] at_least_one(logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // Counts the running wait down; true once it has run out.
    function automatic bit timer_done();
        if (ph_timer <= 16'd1) begin
            ph_timer = '0;
            return 1'b1;
        end
        ph_timer = ph_timer - 16'd1;
        return 1'b0;
    endfunction

    // Hold host and endpoint in reset, clear the endpoint, start the quiesce wait.
    function automatic void start_quiesce(t_phase nxt);
        pins.host_reset_n       = 1'b0;
        pins.endpoint_reset_n   = 1'b0;
        pins.endpoint_program_n = 1'b0;
        ph_timer  = at_least_one(cfg.quiesce_ms);
        seq_phase = nxt;
    endfunction

    // One 1 ms tick: scan the buttons, act on requests, step the running
    // phase, and return the pin drives that follow.
    function automatic t_out sequencer_tick(t_in tk);
        logic power_dn;
        logic reset_dn;
        logic want_hard;
        logic want_up;
        power_dn  = !tk.power_key_n;
        reset_dn  = !tk.reset_key_n;
        want_hard = 1'b0;
        want_up   = 1'b0;

        if (rst_pulse != 8'd0) begin
            rst_pulse = rst_pulse - 8'd1;
            if (rst_pulse == 8'd0) pins.host_reset_n = 1'b1;
        end

        if (scan_div == 0) begin
            if (power_dn) begin
                if (!pk_held) begin
                    pk_held = 1'b1;
                    pk_time = '0;
                end else begin
                    pk_time = sat_add(pk_time, SCAN_PERIOD_MS);
                end
            end else if (pk_held) begin
                if (pk_time >= cfg.long_press_ms) want_hard = 1'b1;
                else if (pk_time >= cfg.short_press_ms) want_up = 1'b1;
                pk_held = 1'b0;
                pk_time = '0;
            end

            if (reset_dn) begin
                if (!rk_held) begin
                    rk_held = 1'b1;
                    rk_time = '0;
                end else begin
                    rk_time = sat_add(rk_time, SCAN_PERIOD_MS);
                end
            end else if (rk_held) begin
                if (rk_time >= cfg.reset_press_ms) begin
                    pins.host_reset_n = 1'b0;
                    rst_pulse = (cfg.reset_pulse_ms == 8'd0) ? 8'd1 : cfg.reset_pulse_ms;
                    n_pulses++;
                end
                rk_held = 1'b0;
                rk_time = '0;
            end
        end
        scan_div = (scan_div + 1 >= SCAN_PERIOD_MS) ? 0 : scan_div + 1;

        // Button requests win over the running phase; hard-off is refused
        // only while already powering down.
        if (want_hard && sys_st != SYS_DOWN) begin
            sys_st = SYS_DOWN;
            pins.host_button_n = 1'b0;
            ph_timer  = at_least_one(cfg.host_button_off_ms);
            seq_phase = PH_HARD_BTN;
            n_hard++;
        end else if (want_up && sys_st == SYS_OFF) begin
            sys_st = SYS_UP;
            pins.host_main_power = 1'b1;
            pins.host_reset_n    = 1'b1;
            pins.endpoint_power  = 1'b1;
            ph_timer  = '0;
            seq_phase = PH_WAIT_PG;
        end else begin
            case (seq_phase)
                PH_IDLE: begin
                    // host went to sleep while on: soft-off
                    if (sys_st == SYS_ON && !tk.host_sleep_n) begin
                        sys_st = SYS_DOWN;
                        pins.host_power_ok = 1'b0;
                        start_quiesce(PH_SOFT_QUIESCE);
                        n_soft++;
                    end
                end
                PH_WAIT_PG: begin
                    if (tk.endpoint_power_good) begin
                        pins.led_power_good     = 1'b1;
                        pins.endpoint_program_n = 1'b1;
                        pins.endpoint_reset_n   = 1'b1;
                        seq_phase = PH_WAIT_DONE;
                    end
                end
                PH_WAIT_DONE: begin
                    if (tk.endpoint_config_done) begin
                        pins.led_config_done = 1'b1;
                        pins.host_button_n   = 1'b0;
                        ph_timer  = at_least_one(cfg.host_button_on_ms);
                        seq_phase = PH_HOST_BTN_ON;
                    end
                end
                PH_HOST_BTN_ON: begin
                    if (timer_done()) begin
                        pins.host_button_n = 1'b1;
                        seq_phase = PH_WAIT_HOST;
                    end
                end
                PH_WAIT_HOST: begin
                    if (tk.host_sleep_n) begin
                        pins.host_power_ok    = 1'b1;
                        pins.led_host_started = 1'b1;
                        sys_st    = SYS_ON;
                        seq_phase = PH_IDLE;
                        n_on++;
                    end
                end
                PH_SOFT_QUIESCE, PH_HARD_QUIESCE: begin
                    if (timer_done()) begin
                        pins.endpoint_power   = 1'b0;
                        pins.host_power_ok    = 1'b0;
                        pins.host_main_power  = 1'b0;
                        pins.led_power_good   = 1'b0;
                        pins.led_host_started = 1'b0;
                        pins.led_config_done  = 1'b0;
                        sys_st    = SYS_OFF;
                        seq_phase = PH_IDLE;
                        ph_timer  = '0;
                    end
                end
                PH_HARD_BTN: begin
                    if (timer_done()) begin
                        pins.host_button_n = 1'b1;
                        ph_timer  = '0;
                        seq_phase = PH_WAIT_STOP;
                    end
                end
                PH_WAIT_STOP: begin
                    // host stopped, or it never did within the timeout
                    if (!tk.host_sleep_n || ph_timer >= cfg.stop_wait_ms)
                        start_quiesce(PH_HARD_QUIESCE);
                    else
                        ph_timer = sat_add(ph_timer, 1);
                end
                default: begin
                    seq_phase = PH_IDLE;
                    ph_timer  = '0;
                end
            endcase
        end

        return t_out'({pins, sys_st});
    endfunction

    // ------------------------------------------------------------------
    // Tick driver: feeds pending ticks, predicts each accepted transfer
    // ------------------------------------------------------------------
    always @(posedge clk) begin : tick_driver
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                want_drives.push_back(sequencer_tick(in_data));
                n_ticks++;
            end
            // a stalled transfer keeps its payload; otherwise load or idle
            if (!in_valid || !in_stall) begin
                if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_ticks.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random stalls, field-by-field compare
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
        if (got !== want) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk) begin : drive_monitor
        t_out want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (want_drives.size() == 0) begin
                    $display("%0t: result transfer with nothing expected: expected none, actual %h",
                             $time, out_data);
                    n_errors++;
                end else begin
                    want = want_drives.pop_front();
                    check_field("host_main_power", want.host_main_power, out_data.host_main_power);
                    check_field("host_reset_n", want.host_reset_n, out_data.host_reset_n);
                    check_field("endpoint_power", want.endpoint_power, out_data.endpoint_power);
                    check_field("endpoint_reset_n", want.endpoint_reset_n,
                                out_data.endpoint_reset_n);
                    check_field("endpoint_program_n", want.endpoint_program_n,
                                out_data.endpoint_program_n);
                    check_field("host_button_n", want.host_button_n, out_data.host_button_n);
                    check_field("host_power_ok", want.host_power_ok, out_data.host_power_ok);
                    check_field("led_power_good", want.led_power_good, out_data.led_power_good);
                    check_field("led_host_started", want.led_host_started,
                                out_data.led_host_started);
                    check_field("led_config_done", want.led_config_done,
                                out_data.led_config_done);
                    check_field("power_state", want.power_state, out_data.power_state);
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_ticks(int n, logic pk, logic rk, logic pg, logic dn, logic sl);
        t_in tk;
        tk.power_key_n          = pk;
        tk.reset_key_n          = rk;
        tk.endpoint_power_good  = pg;
        tk.endpoint_config_done = dn;
        tk.host_sleep_n         = sl;
        repeat (n) begin
            pending_ticks.push_back(tk);
            ticks_made++;
        end
    endtask

    // Ticks with the given keys; power-good, done and host sleep wander on
    // their own, each held for a random dwell and biased toward asserted.
    task automatic push_env(int n, logic pk, logic rk);
        repeat (n) begin
            if (env_dwell == 0) begin
                env_pg    = ($urandom_range(0, 99) < 75);
                env_dn    = ($urandom_range(0, 99) < 70);
                env_sl    = ($urandom_range(0, 99) < 70);
                env_dwell = $urandom_range(1, 40);
            end else begin
                env_dwell--;
            end
            push_ticks(1, pk, rk, env_pg, env_dn, env_sl);
        end
    endtask

    // Button hold length in ticks around a pair of thresholds: a tap, a hold
    // between them, a hold past the upper one, or anything.
    function automatic int hold_len(int lo, int hi);
        int h;
        case ($urandom_range(0, 3))
            0:       h = $urandom_range(1, 30);
            1:       h = $urandom_range(lo + 20, hi + 20);
            2:       h = $urandom_range(hi + 20, hi + 60);
            default: h = $urandom_range(1, hi + 60);
        endcase
        return (h > 160) ? 160 : h;
    endfunction

    function automatic t_cfg random_settings();
        t_cfg c;
        c.short_press_ms       = 16'($urandom_range(1, 60));
        c.long_press_ms        = 16'($urandom_range(40, 120));
        c.reset_press_ms       = 16'($urandom_range(1, 80));
        c.host_button_on_ms    = 16'($urandom_range(1, 30));
        c.host_button_off_ms   = 16'($urandom_range(1, 40));
        c.stop_wait_ms         = 16'($urandom_range(1, 400));
        c.quiesce_ms           = 16'($urandom_range(1, 30));
        c.reset_pulse_ms       = 8'($urandom_range(1, 40));
        return c;
    endfunction

    // Waits, at a falling edge, until every tick is in and every result out.
    task automatic drain();
        do @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || want_drives.size() != 0);
    endtask

    // One register write; valid stays up for a following write.
    task automatic write_reg(t_cfg_idx idx, logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_SHORT_PRESS:  cfg.short_press_ms       = d;
            CFG_LONG_PRESS:   cfg.long_press_ms        = d;
            CFG_RESET_PRESS:  cfg.reset_press_ms       = d;
            CFG_HOST_BTN_ON:  cfg.host_button_on_ms    = d;
            CFG_HOST_BTN_OFF: cfg.host_button_off_ms   = d;
            CFG_STOP_TIMEOUT: cfg.stop_wait_ms         = d;
            CFG_QUIESCE:      cfg.quiesce_ms           = d;
            CFG_RESET_PULSE:  cfg.reset_pulse_ms       = d[7:0];
            default: ;
        endcase
    endtask

    // Writes all eight timing registers back to back; call only when drained.
    task automatic load_settings(t_cfg c);
        @(posedge clk);
        write_reg(CFG_SHORT_PRESS, c.short_press_ms);
        write_reg(CFG_LONG_PRESS, c.long_press_ms);
        write_reg(CFG_RESET_PRESS, c.reset_press_ms);
        write_reg(CFG_HOST_BTN_ON, c.host_button_on_ms);
        write_reg(CFG_HOST_BTN_OFF, c.host_button_off_ms);
        write_reg(CFG_STOP_TIMEOUT, c.stop_wait_ms);
        write_reg(CFG_QUIESCE, c.quiesce_ms);
        write_reg(CFG_RESET_PULSE, {8'd0, c.reset_pulse_ms});
        cfg_valid <= 1'b0;
        n_settings++;
        @(negedge clk);
    endtask

    // Button sequences with random content; every sequence ends released.
    task automatic random_phase(int n);
        int stop_at;
        int kind;
        stop_at = ticks_made + n;
        while (ticks_made < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                push_env(hold_len(int'(cfg.short_press_ms), int'(cfg.long_press_ms)),
                         1'b0, 1'b1);
            end else if (kind == 4) begin
                push_env(hold_len(int'(cfg.reset_press_ms), int'(cfg.reset_press_ms)),
                         1'b1, 1'b0);
            end else if (kind == 5) begin
                // both buttons, reset let go later
                push_env(hold_len(int'(cfg.short_press_ms), int'(cfg.long_press_ms)),
                         1'b0, 1'b0);
                push_env($urandom_range(1, 60), 1'b1, 1'b0);
            end else begin
                // quiet stretch with the odd key bounce
                repeat ($urandom_range(1, 60))
                    push_env(1, $urandom_range(0, 99) >= 3, $urandom_range(0, 99) >= 3);
            end
            push_env($urandom_range(1, 40), 1'b1, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : test_flow
        t_cfg c;
        cfg = '{DEF_SHORT_PRESS, DEF_LONG_PRESS, DEF_RESET_PRESS, DEF_HOST_BTN_ON,
                DEF_HOST_BTN_OFF, DEF_STOP_TIMEOUT, DEF_QUIESCE, DEF_RESET_PULSE};
        sys_st    = SYS_OFF;
        seq_phase = PH_IDLE;
        ph_timer  = '0;
        scan_div  = 0;
        pk_held   = 1'b0;
        pk_time   = '0;
        rk_held   = 1'b0;
        rk_time   = '0;
        rst_pulse = '0;
        pins      = PINS_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: a short reset-button hold is far below the default
        // threshold and must leave every pin alone.
        push_ticks(25, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
        push_ticks(25, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
        drain();

        // Directed part on short, known timings: short 20, long 60, reset 20,
        // host button 3 on / 3 off, stop timeout 5, quiesce 2, reset pulse 4.
        // A 50-tick hold always spans 2-3 scans (short), 100 ticks 5 (long).
        load_settings('{16'd20, 16'd60, 16'd20, 16'd3, 16'd3, 16'd5, 16'd2, 8'd4});
        push_ticks(5, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        // power-up that stalls waiting for power-good
        push_ticks(50, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        push_ticks(25, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        // power-good, then done, host button pulse, host still asleep, then on
        push_ticks(4, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        push_ticks(10, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        push_ticks(3, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        // short press while on is ignored
        push_ticks(50, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        push_ticks(25, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        // host sleep falls while on: soft-off
        push_ticks(6, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        // straight-through power-up
        push_ticks(50, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        push_ticks(30, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        // hard-off with the host never stopping: stop wait times out
        push_ticks(100, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        push_ticks(30, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        // hard-off while already off still runs the whole sequence
        push_ticks(100, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        push_ticks(25, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        // power-up aborted by hard-off while waiting for power-good
        push_ticks(50, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        push_ticks(25, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        push_ticks(100, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        push_ticks(30, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
        // both buttons let go together: pulse and power-up in one tick, the
        // sequencer's release of host reset wins over the pulse
        push_ticks(50, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_ticks(30, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        // reset pulse alone during power-up
        push_ticks(50, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        push_ticks(30, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        drain();

        // Random part: varied timings, minimum and maximum register values,
        // idling first on one side then the other, then none at all.
        for (int p = 0; p < 7; p++) begin
            case (p)
                1:       c = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 8'd1};
                5:       c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'hFFFF, 8'hFF};
                // long timers last, as they can leave the sequencer parked
                6:       c = '{16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'hFFFF, 8'hFF};
                default: c = random_settings();
            endcase
            if (p == 2) begin
                send_idle_pct = 54;
                recv_idle_pct = 31;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_settings(c);
            random_phase((p >= 5) ? 1 : 20);
            drain();
        end

        // every tick gives one result, valid the cycle after it is taken; spare
        // cycles at the end catch anything extra
        repeat (8) @(posedge clk);

        $display("Ran %0d ticks under %0d register settings.", n_ticks, n_settings);
        $display("Reached on %0d times; %0d hard-offs, %0d soft-offs, %0d host reset pulses.",
                 n_on, n_hard, n_soft, n_pulses);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #(3_000_000);
        $display("Timed out with %0d ticks pending, %0d results outstanding",
                 pending_ticks.size(), want_drives.size());
        $display("FAILURE");
        $finish;
    end

endmodule
